// ===== src/rhsb_pkg.sv =====
// Constants and stage types shared by the RGB to hue/saturation/brightness pipeline.
package rhsb_pkg;

  localparam int unsigned ChanW   = 8;   // width of one color channel
  localparam int unsigned HueW    = 9;
  localparam int unsigned PctW    = 7;   // width of saturation and brightness
  localparam int unsigned DivSteps = 7;  // quotient bits produced by the divider lanes
  localparam int unsigned RemW    = 15;  // partial remainder width, holds 100 * 255

  localparam logic [HueW-1:0] DegSextant = 9'd60;
  localparam logic [HueW-1:0] DegFull    = 9'd360;
  localparam logic [HueW-1:0] DegBlue    = 9'd240;
  localparam logic [HueW-1:0] DegGreen   = 9'd120;
  localparam logic [PctW-1:0] Percent    = 7'd100;
  localparam logic [ChanW-1:0] ChanMax   = 8'd255;

  // Brightness uses a reciprocal of 255 scaled by 100 * 2^16, then one correction step.
  localparam int unsigned BrightShift = 16;
  localparam int unsigned BrightRecip = (100 * (1 << BrightShift)) / 255;
  localparam int unsigned BrightProdW = ChanW + BrightShift;

  // Input register, prep stage, divider stages, output register.
  localparam int unsigned Latency = DivSteps + 3;

  typedef struct packed {
    logic [ChanW-1:0] num;   // hue spread numerator
    logic [ChanW-1:0] den;   // max - min, zero for gray
    logic [ChanW-1:0] top;   // max channel
    logic [HueW-1:0]  base;  // sextant base angle
    logic             neg;   // subtract the hue quotient from the base
  } sext_t;

  typedef struct packed {
    logic [RemW-1:0]  hrem;
    logic [ChanW-1:0] hdiv;
    logic [RemW-1:0]  srem;
    logic [ChanW-1:0] sdiv;
    logic [PctW-1:0]  hq;
    logic [PctW-1:0]  sq;
    logic [HueW-1:0]  base;
    logic             neg;
    logic [ChanW-1:0] top;
    logic [PctW-1:0]  bright;
  } div_stage_t;

endpackage

// ===== src/rgb_to_hue_sat_bright.sv =====
// Top level: pipelined conversion of an 8-bit RGB pixel to integer hue, saturation, brightness.
//
// Takes one pixel in every clock cycle; busy never rises. Each result appears on
// hue_o, saturation_o and brightness_o for one cycle with valid_o high, in input order.
// Its pixel passes the input register, the operand register, the divider stage registers
// and the output register in that order. The depth is set by the two seven-step restoring
// division lanes (hue spread over range, range over max), one quotient bit per register
// stage, plus an input stage, an operand stage and an output register. The receiver
// cannot stall, so results never wait.
module rgb_to_hue_sat_bright import rhsb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             valid_o,
  output logic [HueW-1:0]  hue_o,
  output logic [PctW-1:0]  saturation_o,
  output logic [PctW-1:0]  brightness_o
);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: sextant select ----------------
  sext_t sx_d, sx_q;
  logic  sx_vld_q;

  always_comb begin
    sx_d.base = '0;
    sx_d.neg  = 1'b0;
    sx_d.num  = '0;
    sx_d.den  = '0;
    sx_d.top  = blue_i;
    if (red_i > green_i) begin
      if (green_i >= blue_i) begin
        sx_d.num = green_i - blue_i;
        sx_d.den = red_i - blue_i;
        sx_d.top = red_i;
      end else if (red_i >= blue_i) begin
        sx_d.base = DegFull;
        sx_d.neg  = 1'b1;
        sx_d.num  = blue_i - green_i;
        sx_d.den  = red_i - green_i;
        sx_d.top  = red_i;
      end else begin
        sx_d.base = DegBlue;
        sx_d.num  = red_i - green_i;
        sx_d.den  = blue_i - green_i;
        sx_d.top  = blue_i;
      end
    end else if (red_i > blue_i) begin
      sx_d.base = DegGreen;
      sx_d.neg  = 1'b1;
      sx_d.num  = red_i - blue_i;
      sx_d.den  = green_i - blue_i;
      sx_d.top  = green_i;
    end else if (green_i > blue_i) begin
      sx_d.base = DegGreen;
      sx_d.num  = blue_i - red_i;
      sx_d.den  = green_i - red_i;
      sx_d.top  = green_i;
    end else if (blue_i != red_i) begin
      sx_d.base = DegBlue;
      sx_d.neg  = 1'b1;
      sx_d.num  = green_i - red_i;
      sx_d.den  = blue_i - red_i;
      sx_d.top  = blue_i;
    end
    // gray pixel keeps base 0, num 0, den 0
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_vld_q <= 1'b0;
    end else begin
      sx_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= sx_d;
  end

  // ---------------- stage 2: dividends, divisors, brightness estimate ----------------
  div_stage_t                 st_q [DivSteps+1];
  logic                       vld_q [DivSteps+1];
  div_stage_t                 prep_d;
  logic [BrightProdW-1:0]     bprod;

  always_comb begin
    bprod         = BrightProdW'(sx_q.top) * BrightProdW'(BrightRecip);
    prep_d.hrem   = RemW'(sx_q.num) * RemW'(DegSextant);
    prep_d.srem   = RemW'(sx_q.den) * RemW'(Percent);
    // a zero divisor only occurs with a zero dividend; use 1 to get a zero quotient
    prep_d.hdiv   = sx_q.den | ChanW'(sx_q.den == '0);
    prep_d.sdiv   = sx_q.top | ChanW'(sx_q.top == '0);
    prep_d.hq     = '0;
    prep_d.sq     = '0;
    prep_d.base   = sx_q.base;
    prep_d.neg    = sx_q.neg;
    prep_d.top    = sx_q.top;
    prep_d.bright = bprod[BrightShift +: PctW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= sx_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= prep_d;
  end

  // ---------------- divider stages: one quotient bit each ----------------
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int unsigned Shift = DivSteps - 1 - k;

    logic [RemW-1:0] htrial;
    logic [RemW-1:0] strial;
    logic [RemW-1:0] bscaled;
    logic [RemW-1:0] bsub;
    logic [RemW-1:0] brem;
    div_stage_t      st_d;

    always_comb begin
      htrial  = RemW'(st_q[k].hdiv) << Shift;
      strial  = RemW'(st_q[k].sdiv) << Shift;
      bscaled = RemW'(st_q[k].top) * RemW'(Percent);
      bsub    = RemW'(st_q[k].bright) * RemW'(ChanMax);
      brem    = bscaled - bsub;
      st_d    = st_q[k];
      if (st_q[k].hrem >= htrial) begin
        st_d.hrem      = st_q[k].hrem - htrial;
        st_d.hq[Shift] = 1'b1;
      end
      if (st_q[k].srem >= strial) begin
        st_d.srem      = st_q[k].srem - strial;
        st_d.sq[Shift] = 1'b1;
      end
      // the reciprocal estimate is at most one low; fix it in the first step
      if (k == 0 && brem >= RemW'(ChanMax)) begin
        st_d.bright = st_q[k].bright + PctW'(1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k+1] <= st_d;
    end
  end

  // ---------------- output register ----------------
  div_stage_t      fin;
  logic [HueW-1:0] hue_d;
  logic            valid_q;
  logic [HueW-1:0] hue_q;
  logic [PctW-1:0] sat_q;
  logic [PctW-1:0] bright_q;

  assign fin   = st_q[DivSteps];
  assign hue_d = fin.neg ? fin.base - HueW'(fin.hq) : fin.base + HueW'(fin.hq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_d;
    sat_q    <= fin.sq;
    bright_q <= fin.bright;
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

  // ---------------- assertions ----------------
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency valid_o)
    else $error("item did not come out after the pipeline latency");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, Latency))
    else $error("result strobe without a matching item");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> hue_o <= DegFull)
    else $error("hue above 360");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (saturation_o <= Percent) && (brightness_o <= Percent))
    else $error("percentage above 100");

endmodule

// ===== sim/tb_rgb_to_hue_sat_bright.sv =====
// Testbench for the RGB to hue/saturation/brightness converter: directed and random pixels.
module tb_rgb_to_hue_sat_bright;
  import rhsb_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandPixels = 1400;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] bright;
  } hsb_t;

  typedef struct {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    bit               known;
    hsb_t             hsb;
  } pixel_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic [ChanW-1:0] red_i = '0;
  logic [ChanW-1:0] green_i = '0;
  logic [ChanW-1:0] blue_i = '0;
  logic             busy;
  logic             valid_o;
  logic [HueW-1:0]  hue_o;
  logic [PctW-1:0]  saturation_o;
  logic [PctW-1:0]  brightness_o;

  hsb_t        pending_hsb[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  // Known results are typed in for gray, primaries, secondaries and the unwrapped 360.
  pixel_row_t pixel_table [22] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   7'd0,   7'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   7'd0,   7'd100}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{9'd0,   7'd0,   7'd50}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   7'd100, 7'd100}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 7'd100, 7'd100}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 7'd100, 7'd100}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  7'd100, 7'd100}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, 7'd100, 7'd100}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, 7'd100, 7'd100}},
    '{8'd255, 8'd0,   8'd1,   1'b1, '{9'd360, 7'd100, 7'd100}},
    '{8'd1,   8'd0,   8'd0,   1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd200, 8'd100, 8'd50,  1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd200, 8'd50,  8'd100, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd100, 8'd50,  8'd200, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd100, 8'd200, 8'd50,  1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd50,  8'd200, 8'd100, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd50,  8'd100, 8'd200, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd200, 8'd200, 8'd50,  1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd200, 8'd50,  8'd50,  1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd50,  8'd50,  8'd200, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd170, 8'd85,  8'd254, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{8'd85,  8'd254, 8'd170, 1'b0, '{9'd0,   7'd0,   7'd0}}
  };

  rgb_to_hue_sat_bright dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .valid_o      (valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic hsb_t calc_hsb(logic [ChanW-1:0] r8, logic [ChanW-1:0] g8,
                                    logic [ChanW-1:0] b8);
    int unsigned r, g, b, hue, sat, top;
    hsb_t res;
    r = 32'(r8);
    g = 32'(g8);
    b = 32'(b8);
    // Tie order matters: each branch claims its boundary before the next one.
    if (r > g) begin
      if (g >= b) begin
        hue = (g - b) * 60 / (r - b);
        sat = (r - b) * 100 / r;
        top = r;
      end else if (r >= b) begin
        hue = 360 - (b - g) * 60 / (r - g);
        sat = (r - g) * 100 / r;
        top = r;
      end else begin
        hue = 240 + (r - g) * 60 / (b - g);
        sat = (b - g) * 100 / b;
        top = b;
      end
    end else if (r > b) begin
      hue = 120 - (r - b) * 60 / (g - b);
      sat = (g - b) * 100 / g;
      top = g;
    end else if (g > b) begin
      hue = 120 + (b - r) * 60 / (g - r);
      sat = (g - r) * 100 / g;
      top = g;
    end else if (b == r) begin
      hue = 0;
      sat = 0;
      top = b;
    end else begin
      hue = 240 - (g - r) * 60 / (b - r);
      sat = (b - r) * 100 / b;
      top = b;
    end
    res.hue = hue[HueW-1:0];
    res.sat = sat[PctW-1:0];
    res.bright = 7'((top * 100) / 255);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Hold the pixel on the ports until the block takes it.
  task automatic send_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b,
                            bit known, hsb_t typed_hsb);
    start <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (busy);
    pending_hsb.push_back(known ? typed_hsb : calc_hsb(r, g, b));
  endtask

  task automatic maybe_idle(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_hsb.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    hsb_t want;
    if (rst_ni && valid_o) begin
      if (pending_hsb.size() == 0) begin
        $display("unexpected result at %0t: hue %0d sat %0d bright %0d",
                 $time, hue_o, saturation_o, brightness_o);
        mismatch_count++;
      end else begin
        want = pending_hsb.pop_front();
        if (hue_o !== want.hue) begin
          report_mismatch("hue", 32'(hue_o), 32'(want.hue));
        end
        if (saturation_o !== want.sat) begin
          report_mismatch("saturation", 32'(saturation_o), 32'(want.sat));
        end
        if (brightness_o !== want.bright) begin
          report_mismatch("brightness", 32'(brightness_o), 32'(want.bright));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= StallLimit) begin
        $display("FAIL rgb_to_hue_sat_bright");
        $finish;
      end
    end
  end

  initial begin
    logic [ChanW-1:0] r, g, b, v, w;
    int unsigned      mode;
    hsb_t             none;
    none = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pixel_table[i]) begin
      send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b,
                 pixel_table[i].known, pixel_table[i].hsb);
      maybe_idle(1'b0);
    end
    drain_results();

    for (int unsigned n = 0; n < RandPixels; n++) begin
      mode = $urandom_range(0, 9);
      r = ChanW'($urandom);
      g = ChanW'($urandom);
      b = ChanW'($urandom);
      v = ChanW'($urandom);
      w = ChanW'($urandom);
      case (mode)
        0: begin
          r = v;
          g = v;
          b = v;
        end
        1: begin
          // Put two channels on a tie to hit the branch boundaries.
          case ($urandom_range(0, 2))
            0: begin r = v; g = v; b = w; end
            1: begin r = v; g = w; b = v; end
            default: begin r = w; g = v; b = v; end
          endcase
        end
        2: begin
          // Near-red magenta side, where the hue quotient can truncate to 360.
          g = ChanW'($urandom_range(0, 100));
          r = ChanW'($urandom_range(32'(g) + 61, 255));
          b = ChanW'(32'(g) + $urandom_range(0, 3));
        end
        default: ;
      endcase
      send_pixel(r, g, b, 1'b0, none);
      if (n == RandPixels / 2) drain_results();
      maybe_idle(n >= 400 && n < 700);
    end

    drain_results();
    repeat (Latency + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS rgb_to_hue_sat_bright");
    end else begin
      $display("FAIL rgb_to_hue_sat_bright");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hue_sat_bright.f =====
src/rhsb_pkg.sv
src/rgb_to_hue_sat_bright.sv
sim/tb_rgb_to_hue_sat_bright.sv
